@@ hw/rtl/lic_pkg.sv @@
// ----------------------------------------------------------------------------
// lic_pkg: shared definitions for the index/coordinate converter
// Field widths, register indexes, direction codes and default parameters.
// ----------------------------------------------------------------------------
package lic_pkg;

  // Fixed field widths of the channels
  localparam int unsigned FLAT_W    = 32;
  localparam int unsigned CRD_W     = 16;
  localparam int unsigned SIZE_W    = 16;
  localparam int unsigned NDIM_W    = 3;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned NREG_DIMS = 4;

  // Default parameter values
  localparam int unsigned DEF_MAX_DIMS   = 4;
  localparam int unsigned DEF_COORD_BITS = 16;
  localparam int unsigned DEF_INDEX_BITS = 32;

  // Register indexes on the configuration port
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_NUM_DIMS = 3'd0,
    REG_SIZE_D0  = 3'd1,
    REG_SIZE_D1  = 3'd2,
    REG_SIZE_D2  = 3'd3,
    REG_SIZE_D3  = 3'd4
  } cfg_reg_e;

  // Conversion direction
  typedef enum logic {
    KIND_IDX_TO_CRD = 1'b0,
    KIND_CRD_TO_IDX = 1'b1
  } kind_e;

  typedef logic [NREG_DIMS-1:0][SIZE_W-1:0] size_arr_t;

endpackage

@@ hw/rtl/lic_if.sv @@
// ----------------------------------------------------------------------------
// lic_if: channel interfaces of the index/coordinate converter
// Input, output and configuration channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface lic_in_if;
  import lic_pkg::*;
  logic              valid;
  logic              ready;
  logic              kind;
  logic [FLAT_W-1:0] flat_index;
  logic [CRD_W-1:0]  coord_in_0;
  logic [CRD_W-1:0]  coord_in_1;
  logic [CRD_W-1:0]  coord_in_2;
  logic [CRD_W-1:0]  coord_in_3;
  modport source (output valid, kind, flat_index, coord_in_0, coord_in_1, coord_in_2,
                  coord_in_3, input ready);
  modport sink (input valid, kind, flat_index, coord_in_0, coord_in_1, coord_in_2,
                coord_in_3, output ready);
endinterface

interface lic_out_if;
  import lic_pkg::*;
  logic              valid;
  logic              ready;
  logic [FLAT_W-1:0] flat_index_out;
  logic [CRD_W-1:0]  coord_out_0;
  logic [CRD_W-1:0]  coord_out_1;
  logic [CRD_W-1:0]  coord_out_2;
  logic [CRD_W-1:0]  coord_out_3;
  logic              out_of_range;
  modport source (output valid, flat_index_out, coord_out_0, coord_out_1, coord_out_2,
                  coord_out_3, out_of_range, input ready);
  modport sink (input valid, flat_index_out, coord_out_0, coord_out_1, coord_out_2,
                coord_out_3, out_of_range, output ready);
endinterface

interface lic_cfg_if;
  import lic_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] addr;
  logic [SIZE_W-1:0]    data;
  modport source (output valid, addr, data, input ready);
  modport sink (input valid, addr, data, output ready);
endinterface

@@ hw/rtl/lic_cell.sv @@
// ----------------------------------------------------------------------------
// lic_cell: one cell of the conversion chain
// Performs one restoring divide step for index to coordinates, and in the
// first two cells of a section the multiply and the add for the weighted sum.
// ----------------------------------------------------------------------------
module lic_cell #(
  parameter type         item_t     = logic,
  parameter int unsigned IW         = 32,
  parameter int unsigned IB         = 32,
  parameter int unsigned COORD_BITS = 16,
  parameter int unsigned SEC        = 0,
  parameter int unsigned BIT        = 0
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            adv_i,
  input  logic [lic_pkg::NDIM_W-1:0]      ndims_i,
  input  lic_pkg::size_arr_t              sizes_i,
  input  item_t                           item_i,
  output item_t                           item_o
);
  import lic_pkg::*;

  localparam int unsigned PW = IB + SIZE_W;
  localparam int unsigned SW = ((IB > SIZE_W) ? IB : SIZE_W) + 1;
  localparam logic [32:0] CMASK = (33'd1 << COORD_BITS) - 33'd1;
  localparam logic [64:0] IMASK = (65'd1 << IB) - 65'd1;
  localparam logic [1:0]  DM    = 2'(SEC + 1);

  item_t             item_d, item_q;
  logic              sec_act;
  logic [1:0]        ddiv;
  logic [SIZE_W-1:0] s_div;
  logic [SIZE_W:0]   r_sh;
  logic              ge;
  logic [SIZE_W:0]   r_nx;
  logic [PW-1:0]     prod;
  logic [SW-1:0]     sum;

  // Section covers the divide of dimension n-1-SEC and the mac of SEC+1
  assign sec_act = (3'(SEC) + 3'd1) < ndims_i;
  assign ddiv    = 2'(ndims_i - 3'd1 - 3'(SEC));
  assign s_div   = sizes_i[ddiv];
  assign r_sh    = {item_i.rem, item_i.quo[IW-1]};
  assign ge      = r_sh >= {1'b0, s_div};
  assign r_nx    = ge ? (r_sh - {1'b0, s_div}) : r_sh;
  assign prod    = PW'(item_i.acc) * PW'(sizes_i[DM]);
  assign sum     = SW'(item_i.acc) + SW'(item_i.cin[DM]);

  // Step the word
  always_comb begin
    item_d = item_i;
    if (item_i.vld && sec_act) begin
      if (item_i.kind == KIND_IDX_TO_CRD) begin
        item_d.quo = {item_i.quo[IW-2:0], ge};
        item_d.rem = r_nx[SIZE_W-1:0];
        if (BIT == IW - 1) begin
          item_d.crd[ddiv] = r_nx[CRD_W-1:0] & CMASK[CRD_W-1:0];
          if (33'(r_nx[SIZE_W-1:0]) > CMASK) item_d.flag = 1'b1;
          item_d.rem = '0;
        end
      end else begin
        if (BIT == 0) begin
          if (item_i.cin[DM] >= sizes_i[DM]) item_d.flag = 1'b1;
          if (prod[PW-1:IB] != '0) item_d.flag = 1'b1;
          item_d.acc = prod[IB-1:0];
        end else if (BIT == 1) begin
          if ((65'(item_i.cin[DM]) <= IMASK) && (65'(sum) > IMASK)) item_d.flag = 1'b1;
          item_d.acc = sum[IB-1:0];
        end
      end
    end
  end

  // Hand on to the neighbor
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_q <= '0;
    end else if (adv_i) begin
      item_q <= item_d;
    end
  end

  assign item_o = item_q;

endmodule

@@ hw/rtl/linear_index_coordinate_converter.sv @@
// Throughput: one word per cycle; every cell of the divide chain takes a new
// word each cycle, and the chain length is set by one quotient bit per cell.
// A stalled output holds the whole chain.
// Reset: asynchronous, active low; clears the pipeline and loads the default
// register values (two dimensions of 256 by 256).
// ----------------------------------------------------------------------------
// linear_index_coordinate_converter: row-major index to coordinates and back
// Entry register, chain of divide/mac cells, and final check and output stage.
// ----------------------------------------------------------------------------
module linear_index_coordinate_converter #(
  parameter int unsigned MAX_DIMS   = lic_pkg::DEF_MAX_DIMS,
  parameter int unsigned COORD_BITS = lic_pkg::DEF_COORD_BITS,
  parameter int unsigned INDEX_BITS = lic_pkg::DEF_INDEX_BITS
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  lic_in_if.sink        in_i,
  lic_out_if.source     out_o,
  lic_cfg_if.sink       cfg_i
);
  import lic_pkg::*;

  localparam int unsigned ND    = (MAX_DIMS < NREG_DIMS) ? MAX_DIMS : NREG_DIMS;
  localparam int unsigned IW    = (INDEX_BITS < FLAT_W) ? INDEX_BITS : FLAT_W;
  localparam int unsigned IB    = INDEX_BITS;
  localparam int unsigned NCELL = (ND - 1) * IW;
  localparam logic [32:0] CMASK = (33'd1 << COORD_BITS) - 33'd1;

  typedef struct packed {
    logic                         vld;
    kind_e                        kind;
    logic                         flag;
    logic [IW-1:0]                quo;
    logic [SIZE_W-1:0]            rem;
    logic [NREG_DIMS-1:0][CRD_W-1:0] crd;
    logic [NREG_DIMS-1:0][CRD_W-1:0] cin;
    logic [IB-1:0]                acc;
  } item_t;

  typedef struct packed {
    logic                         valid;
    logic [FLAT_W-1:0]            flat;
    logic [NREG_DIMS-1:0][CRD_W-1:0] crd;
    logic                         oor;
  } res_t;

  logic [NDIM_W-1:0] ndims_q;
  size_arr_t         sizes_q;
  logic [NDIM_W-1:0] nuse;
  logic              adv;
  item_t             entry_d, entry_q;
  item_t             chain [NCELL+1];
  item_t             last;
  res_t              res_d, res_q;
  logic              zero_sz;

  // Configuration registers
  assign cfg_i.ready = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ndims_q <= 3'd2;
      sizes_q <= {16'd1, 16'd1, 16'd256, 16'd256};
    end else if (cfg_i.valid) begin
      case (cfg_reg_e'(cfg_i.addr))
        REG_NUM_DIMS: ndims_q    <= cfg_i.data[NDIM_W-1:0];
        REG_SIZE_D0:  sizes_q[0] <= cfg_i.data;
        REG_SIZE_D1:  sizes_q[1] <= cfg_i.data;
        REG_SIZE_D2:  sizes_q[2] <= cfg_i.data;
        REG_SIZE_D3:  sizes_q[3] <= cfg_i.data;
        default: ;
      endcase
    end
  end

  // Clamp the dimension count
  always_comb begin
    nuse = ndims_q;
    if (nuse == 3'd0) nuse = 3'd1;
    if (nuse > 3'(ND)) nuse = 3'(ND);
  end

  // Advance whenever the output register is free or being taken
  assign adv        = !res_q.valid || out_o.ready;
  assign in_i.ready = adv;

  // Build the entry word
  always_comb begin
    entry_d        = '0;
    entry_d.vld    = in_i.valid;
    entry_d.kind   = kind_e'(in_i.kind);
    entry_d.quo    = in_i.flat_index[IW-1:0];
    entry_d.cin[0] = in_i.coord_in_0 & CMASK[CRD_W-1:0];
    entry_d.cin[1] = in_i.coord_in_1 & CMASK[CRD_W-1:0];
    entry_d.cin[2] = in_i.coord_in_2 & CMASK[CRD_W-1:0];
    entry_d.cin[3] = in_i.coord_in_3 & CMASK[CRD_W-1:0];
    entry_d.acc    = IB'(entry_d.cin[0]);
    entry_d.flag   = (in_i.kind == KIND_CRD_TO_IDX) && (entry_d.cin[0] >= sizes_q[0]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entry_q <= '0;
    end else if (adv) begin
      entry_q <= entry_d;
    end
  end

  assign chain[0] = entry_q;

  // Chain of cells, one section per faster dimension
  for (genvar s = 0; s < ND - 1; s++) begin : g_sec
    for (genvar b = 0; b < IW; b++) begin : g_bit
      lic_cell #(
        .item_t     (item_t),
        .IW         (IW),
        .IB         (IB),
        .COORD_BITS (COORD_BITS),
        .SEC        (s),
        .BIT        (b)
      ) u_cell (
        .clk_i   (clk_i),
        .rst_ni  (rst_ni),
        .adv_i   (adv),
        .ndims_i (nuse),
        .sizes_i (sizes_q),
        .item_i  (chain[s*IW+b]),
        .item_o  (chain[s*IW+b+1])
      );
    end
  end

  assign last = chain[NCELL];

  // Finish: leftover quotient is coordinate zero; range and zero-size checks
  always_comb begin
    zero_sz = 1'b0;
    for (int d = 0; d < NREG_DIMS; d++) begin
      if ((3'(d) < nuse) && (sizes_q[d] == '0)) zero_sz = 1'b1;
    end
    res_d       = '0;
    res_d.valid = last.vld;
    res_d.oor   = last.flag;
    if (last.kind == KIND_IDX_TO_CRD) begin
      res_d.crd    = last.crd;
      res_d.crd[0] = CRD_W'(last.quo) & CMASK[CRD_W-1:0];
      if ((33'(last.quo) >= 33'(sizes_q[0])) || (33'(last.quo) > CMASK)) res_d.oor = 1'b1;
      if (zero_sz) begin
        res_d.crd = '0;
        res_d.oor = 1'b1;
      end
    end else begin
      res_d.flat = FLAT_W'(last.acc);
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_q <= '0;
    end else if (adv) begin
      res_q <= res_d;
    end
  end

  assign out_o.valid          = res_q.valid;
  assign out_o.flat_index_out = res_q.flat;
  assign out_o.coord_out_0    = res_q.crd[0];
  assign out_o.coord_out_1    = res_q.crd[1];
  assign out_o.coord_out_2    = res_q.crd[2];
  assign out_o.coord_out_3    = res_q.crd[3];
  assign out_o.out_of_range   = res_q.oor;

`ifndef SYNTHESIS
  // An accepted word shows up in the entry register
  a_entry_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready) |=> entry_q.vld)
    else $error("accepted word missing from entry register");

  // A stall freezes the end of the chain
  a_chain_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !adv |=> $stable(last))
    else $error("chain moved during stall");

  // A result carries either an index or coordinates, never both
  a_dir_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_q.valid && (res_q.crd != '0)) |-> (res_q.flat == '0))
    else $error("index and coordinates both nonzero");
`endif

endmodule
